@@ hdl/xxtea_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XXTEA package
// Shared constants, the block job descriptor and the cipher helper functions.
// ----------------------------------------------------------------------------
package xxtea_pkg;

    localparam int STORE_DEPTH       = 64;
    localparam int ADDR_W            = 6;
    localparam int CNT_W             = 7;
    localparam int BYTES_W           = 9;
    localparam int DEFAULT_MAX_WORDS = 32;
    localparam int QUEUE_DEPTH       = 2;
    localparam int QPTR_W            = 1;
    localparam int CFG_IDX_W         = 3;

    localparam logic [31:0] DELTA = 32'h9e3779b9;

    localparam logic [CFG_IDX_W-1:0] REG_KEY0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ADD_LEN = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LEN_ERR  = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    typedef struct packed {
        logic               mode;
        logic               ovf;
        logic [CNT_W-1:0]   cnt;
        logic [BYTES_W-1:0] bytes;
    } t_job;

    // Clear the bytes above cnt; a count of zero clears the whole word.
    function automatic logic [31:0] keep_bytes(input logic [31:0] w, input logic [2:0] cnt);
        logic [31:0] r;
        begin
            case (cnt)
                3'd0:    r = 32'd0;
                3'd1:    r = {24'd0, w[7:0]};
                3'd2:    r = {16'd0, w[15:0]};
                3'd3:    r = {8'd0, w[23:0]};
                default: r = w;
            endcase
            return r;
        end
    endfunction

    // Every byte after the first zero byte of the key is cleared.
    function automatic logic [127:0] fix_key(input logic [127:0] raw);
        logic [127:0] k;
        logic         zs;
        begin
            k  = '0;
            zs = 1'b0;
            for (int i = 0; i < 16; i++) begin
                if (!zs) k[i*8 +: 8] = raw[i*8 +: 8];
                if (raw[i*8 +: 8] == 8'd0) zs = 1'b1;
            end
            return k;
        end
    endfunction

    function automatic logic [31:0] mix(input logic [31:0] z, input logic [31:0] y,
                                        input logic [31:0] sum, input logic [31:0] kw);
        begin
            return (((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4))) ^ ((sum ^ y) + (kw ^ z));
        end
    endfunction

    // 6 + 52/len for len of 2 or more, counted as the multiples of len that fit in 52.
    function automatic logic [5:0] round_count(input logic [CNT_W-1:0] len);
        logic [5:0] q;
        begin
            q = 6'd6;
            for (int k = 1; k <= 26; k++) begin
                if (k * int'(len) <= 52) q = q + 6'd1;
            end
            return q;
        end
    endfunction

endpackage

@@ hdl/xxtea_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XXTEA generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module xxtea_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/xxtea_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XXTEA front end
// Takes input words into the store and hands a job descriptor per block on.
// ----------------------------------------------------------------------------
module xxtea_front #(
    parameter int MAX_WORDS = xxtea_pkg::DEFAULT_MAX_WORDS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_tvalid,
    output logic                        o_tready,
    input  logic                        i_action,
    input  logic [31:0]                 i_data,
    input  logic [2:0]                  i_count,
    input  logic                        i_last,
    output logic                        o_we,
    output logic [xxtea_pkg::ADDR_W-1:0] o_waddr,
    output logic [31:0]                 o_wdata,
    output logic                        o_push,
    output xxtea_pkg::t_job             o_job,
    input  logic                        i_done
);
    import xxtea_pkg::*;

    logic               r_busy, n_busy;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [BYTES_W-1:0] r_bytes, n_bytes;
    logic               r_mode, n_mode;
    logic               r_ovf, n_ovf;

    logic               acc, store_ok, mode_c;
    logic [2:0]         cnt_c;
    logic [CNT_W-1:0]   cnt_inc;
    logic [BYTES_W-1:0] bytes_inc;

    assign o_tready  = !r_busy;
    assign acc       = i_tvalid && !r_busy;
    assign cnt_c     = (i_count > 3'd4) ? 3'd4 : i_count;
    assign store_ok  = r_count < CNT_W'(MAX_WORDS);
    assign mode_c    = (r_count == '0 && !r_ovf) ? i_action : r_mode;
    assign cnt_inc   = r_count + CNT_W'(1);
    assign bytes_inc = r_bytes + BYTES_W'(cnt_c);

    assign o_we    = acc && store_ok;
    assign o_waddr = r_count[ADDR_W-1:0];
    assign o_wdata = keep_bytes(i_data, cnt_c);
    assign o_push  = acc && i_last;

    always_comb begin
        o_job.mode  = mode_c;
        o_job.ovf   = r_ovf || !store_ok;
        o_job.cnt   = store_ok ? cnt_inc : r_count;
        o_job.bytes = store_ok ? bytes_inc : r_bytes;
    end

    always_comb begin
        n_busy  = r_busy;
        n_count = r_count;
        n_bytes = r_bytes;
        n_mode  = r_mode;
        n_ovf   = r_ovf;
        if (i_done) n_busy = 1'b0;
        if (acc) begin
            n_mode = mode_c;
            if (store_ok) begin
                n_count = cnt_inc;
                n_bytes = bytes_inc;
            end else begin
                n_ovf = 1'b1;
            end
            if (i_last) begin
                n_busy  = 1'b1;
                n_count = '0;
                n_bytes = '0;
                n_ovf   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
            r_bytes <= '0;
            r_mode  <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_count <= n_count;
            r_bytes <= n_bytes;
            r_mode  <= n_mode;
            r_ovf   <= n_ovf;
        end
    end

    a_no_store_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_we) else $error("front wrote the store during a job");
    a_push_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> r_busy) else $error("front accepted after a block end");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_WORDS)) else $error("word count beyond limit");

endmodule

@@ hdl/xxtea_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XXTEA job queue
// Short descriptor queue between the front end and the cipher engine.
// ----------------------------------------------------------------------------
module xxtea_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  xxtea_pkg::t_job i_job,
    input  logic            i_pop,
    output logic            o_valid,
    output xxtea_pkg::t_job o_job
);
    import xxtea_pkg::*;

    t_job              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_fill;
    logic              do_push, do_pop;

    assign o_valid = r_fill != '0;
    assign o_job   = r_slot[r_rp];
    assign do_push = i_push && (r_fill != (QPTR_W+1)'(QUEUE_DEPTH));
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_slot[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + QPTR_W'(1);
            if (do_pop) r_rp <= r_rp + QPTR_W'(1);
            case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + (QPTR_W+1)'(1);
                2'b01:   r_fill <= r_fill - (QPTR_W+1)'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

@@ hdl/xxtea_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XXTEA cipher engine
// Runs the XXTEA rounds over the store, checks the length word, emits items.
// ----------------------------------------------------------------------------
module xxtea_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    input  xxtea_pkg::t_job              i_job,
    output logic                         o_pop,
    input  logic [127:0]                 i_key,
    input  logic                         i_add_len,
    output logic                         o_we,
    output logic [xxtea_pkg::ADDR_W-1:0] o_waddr,
    output logic [31:0]                  o_wdata,
    output logic [xxtea_pkg::ADDR_W-1:0] o_raddr,
    input  logic [31:0]                  i_rdata,
    output logic                         o_tvalid,
    input  logic                         i_tready,
    output logic [31:0]                  o_word,
    output logic [2:0]                   o_vb,
    output logic                         o_last,
    output logic [1:0]                   o_status,
    output logic                         o_done
);
    import xxtea_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_WLEN   = 5'd1;
    localparam logic [4:0] S_Q      = 5'd2;
    localparam logic [4:0] S_SUM    = 5'd3;
    localparam logic [4:0] S_INIT_A = 5'd4;
    localparam logic [4:0] S_INIT_B = 5'd5;
    localparam logic [4:0] S_INIT_C = 5'd6;
    localparam logic [4:0] S_ROUND  = 5'd7;
    localparam logic [4:0] S_STEP_A = 5'd8;
    localparam logic [4:0] S_STEP_B = 5'd9;
    localparam logic [4:0] S_STEP_C = 5'd10;
    localparam logic [4:0] S_FIN    = 5'd11;
    localparam logic [4:0] S_CHK_A  = 5'd12;
    localparam logic [4:0] S_CHK_B  = 5'd13;
    localparam logic [4:0] S_EMIT_A = 5'd14;
    localparam logic [4:0] S_EMIT_B = 5'd15;
    localparam logic [4:0] S_FLAG   = 5'd16;

    logic [4:0]         r_state, n_state;
    logic               r_mode;
    logic [BYTES_W-1:0] r_bytes;
    logic [CNT_W-1:0]   r_len;
    logic [ADDR_W-1:0]  r_n, r_p;
    logic [5:0]         r_q;
    logic [31:0]        r_sum, r_c, r_t, r_nb, r_mix;
    logic [CNT_W-1:0]   r_words, r_i;
    logic [2:0]         r_lastvb;
    logic               r_trim;
    logic [1:0]         r_flag;
    logic               r_ovalid;
    logic [31:0]        r_oword;
    logic [2:0]         r_ovb;
    logic               r_olast;
    logic [1:0]         r_ost;

    logic               slot_free, is_enc;
    logic [CNT_W-1:0]   job_len;
    logic [ADDR_W-1:0]  nb_idx;
    logic [1:0]         kidx;
    logic [31:0]        kw, mix_c, new_v, sum0;
    logic [8:0]         avail, lo;
    logic [31:0]        m_plus;
    logic               em_last;
    logic [2:0]         em_vb;

    assign slot_free = !r_ovalid || i_tready;
    assign is_enc    = r_mode == MODE_ENC;
    assign job_len   = i_job.cnt + CNT_W'(i_job.mode == MODE_ENC && i_add_len);
    assign nb_idx    = is_enc ? ((r_p == r_n) ? '0 : r_p + ADDR_W'(1))
                              : ((r_p == '0) ? r_n : r_p - ADDR_W'(1));
    assign kidx      = r_p[1:0] ^ r_sum[3:2];
    assign kw        = i_key[{kidx, 5'd0} +: 32];
    assign mix_c     = is_enc ? mix(r_c, i_rdata, r_sum, kw) : mix(i_rdata, r_c, r_sum, kw);
    assign new_v     = is_enc ? r_t + r_mix : r_t - r_mix;
    assign sum0      = (32'(r_q) + 32'd1) * DELTA;
    assign avail     = {1'b0, r_n, 2'b00};
    assign lo        = (avail >= 9'd3) ? avail - 9'd3 : 9'd0;
    assign m_plus    = i_rdata + 32'd3;
    assign em_last   = r_i == r_words - CNT_W'(1);
    assign em_vb     = (em_last && r_trim) ? r_lastvb : 3'd4;

    always_comb begin
        unique case (r_state) inside
            S_INIT_A, S_CHK_A: o_raddr = r_n;
            S_STEP_A:          o_raddr = nb_idx;
            S_EMIT_A, S_EMIT_B: o_raddr = r_i[ADDR_W-1:0];
            default:           o_raddr = '0;
        endcase
    end

    assign o_we    = (r_state == S_WLEN) || (r_state == S_STEP_C);
    assign o_waddr = (r_state == S_WLEN) ? r_n : r_p;
    assign o_wdata = (r_state == S_WLEN) ? 32'(r_bytes) : new_v;
    assign o_pop   = (r_state == S_IDLE) && i_job_valid;
    assign o_done  = ((r_state == S_EMIT_B) && slot_free && em_last)
                  || ((r_state == S_FLAG) && slot_free);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    if (i_job.ovf) n_state = S_FLAG;
                    else if (i_job.mode == MODE_ENC && i_add_len) n_state = S_WLEN;
                    else n_state = S_Q;
                end
            end
            S_WLEN:   n_state = S_Q;
            S_Q:      n_state = (r_len < CNT_W'(2)) ? S_FIN : S_SUM;
            S_SUM:    n_state = S_INIT_A;
            S_INIT_A: n_state = S_INIT_B;
            S_INIT_B: n_state = S_INIT_C;
            S_INIT_C: n_state = S_ROUND;
            S_ROUND:  n_state = (r_q == '0) ? S_FIN : S_STEP_A;
            S_STEP_A: n_state = S_STEP_B;
            S_STEP_B: n_state = S_STEP_C;
            S_STEP_C: begin
                if ((is_enc && r_p == r_n) || (!is_enc && r_p == '0)) n_state = S_ROUND;
                else n_state = S_STEP_A;
            end
            S_FIN:    n_state = (!is_enc && i_add_len) ? S_CHK_A : S_EMIT_A;
            S_CHK_A:  n_state = S_CHK_B;
            S_CHK_B: begin
                if (i_rdata > 32'(avail) || i_rdata < 32'(lo) || i_rdata == '0) n_state = S_FLAG;
                else n_state = S_EMIT_A;
            end
            S_EMIT_A: n_state = S_EMIT_B;
            S_EMIT_B: if (slot_free) n_state = em_last ? S_IDLE : S_EMIT_A;
            S_FLAG:   if (slot_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_tready) r_ovalid <= 1'b0;
            if ((r_state == S_EMIT_B || r_state == S_FLAG) && slot_free) r_ovalid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_mode  <= i_job.mode;
                r_bytes <= i_job.bytes;
                r_len   <= job_len;
                r_n     <= ADDR_W'(job_len - CNT_W'(1));
                r_flag  <= ST_TOO_LONG;
                r_i     <= '0;
                r_trim  <= 1'b0;
            end
            S_Q: begin
                r_q     <= round_count(r_len);
                r_words <= r_len;
            end
            S_SUM:    r_sum <= is_enc ? 32'd0 : sum0;
            S_INIT_B: if (is_enc) r_c <= i_rdata; else r_t <= i_rdata;
            S_INIT_C: begin
                if (is_enc) r_t <= i_rdata; else r_c <= i_rdata;
                r_p <= is_enc ? '0 : r_n;
            end
            S_ROUND: begin
                if (r_q != '0) begin
                    r_q   <= r_q - 6'd1;
                    r_sum <= is_enc ? r_sum + DELTA : r_sum - DELTA;
                end
            end
            S_STEP_B: begin
                r_nb  <= i_rdata;
                r_mix <= mix_c;
            end
            S_STEP_C: begin
                r_c <= new_v;
                r_t <= r_nb;
                r_p <= nb_idx;
            end
            S_CHK_B: begin
                r_flag   <= (i_rdata == '0 && !(i_rdata > 32'(avail) || i_rdata < 32'(lo)))
                            ? ST_OK : ST_LEN_ERR;
                r_words  <= CNT_W'(m_plus[31:2]);
                r_lastvb <= {1'b0, i_rdata[1:0] - 2'd1} + 3'd1;
                r_trim   <= 1'b1;
            end
            S_EMIT_B: if (slot_free) r_i <= r_i + CNT_W'(1);
            default: ;
        endcase
        if (r_state == S_EMIT_B && slot_free) begin
            r_oword <= keep_bytes(i_rdata, em_vb);
            r_ovb   <= em_vb;
            r_olast <= em_last;
            r_ost   <= ST_OK;
        end else if (r_state == S_FLAG && slot_free) begin
            r_oword <= '0;
            r_ovb   <= 3'd0;
            r_olast <= 1'b1;
            r_ost   <= r_flag;
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_word   = r_oword;
    assign o_vb     = r_ovb;
    assign o_last   = r_olast;
    assign o_status = r_ost;

    a_flag_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ost != ST_OK) |-> (r_olast && r_ovb == 3'd0))
        else $error("error item is not a lone final item");
    a_step_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP_C) |-> (r_p <= r_n)) else $error("step index out of block");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (r_state == S_IDLE)) else $error("engine not idle after block");

endmodule

@@ hdl/xxtea_block_cipher_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XXTEA block cipher core
// Gathers a block of words, encrypts or decrypts it with XXTEA, emits it.
// ----------------------------------------------------------------------------
// Words of a block enter on the slave stream, one item per cycle, and are
// written into a 64-word store; the item with tlast closes the block and a
// job descriptor goes through a two-entry queue to the cipher engine. The
// input stays stalled from that item until the engine has loaded the last
// result of the block into its output register. Each mixing step reads the
// store, registers the mix and writes back, each round adds a state of its
// own, and a block of n words needs (6 + 52/n) * n steps; setup, the
// emission of each word and the length check run in states of their own.
// The engine has a single store port for reads. A one-word block skips the
// rounds. Key and add_length are read by the engine while it works on a
// block, so they must only be written while the block is idle.
// ----------------------------------------------------------------------------
module xxtea_block_cipher_core #(
    parameter int MAX_WORDS = xxtea_pkg::DEFAULT_MAX_WORDS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [xxtea_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [31:0]                    i_cfg_wdata,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [39:0]                    i_s_tdata,  // data_word[31:0], byte_count[34:32]
    input  logic [0:0]                     i_s_tuser,  // action[0]
    input  logic                           i_s_tlast,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [39:0]                    o_m_tdata,  // result_word[31:0], valid_bytes[34:32]
    output logic [1:0]                     o_m_tuser,  // status[1:0]
    output logic                           o_m_tlast
);
    import xxtea_pkg::*;

    logic [31:0] r_key0, r_key1, r_key2, r_key3;
    logic        r_add_len;

    // Plain register writes; indexes outside the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0    <= '0;
            r_key1    <= '0;
            r_key2    <= '0;
            r_key3    <= '0;
            r_add_len <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_KEY0:    r_key0    <= i_cfg_wdata;
                REG_KEY1:    r_key1    <= i_cfg_wdata;
                REG_KEY2:    r_key2    <= i_cfg_wdata;
                REG_KEY3:    r_key3    <= i_cfg_wdata;
                REG_ADD_LEN: r_add_len <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic [127:0]      key_fixed;
    logic              f_we, b_we, push, pop, done, q_valid;
    logic [ADDR_W-1:0] f_waddr, b_waddr, raddr;
    logic [31:0]       f_wdata, b_wdata, rdata;
    logic [2:0]        out_vb;
    t_job              f_job, q_job;

    // The key is cut at its first zero byte, as the byte-string key would be.
    assign key_fixed = fix_key({r_key3, r_key2, r_key1, r_key0});

    xxtea_front #(.MAX_WORDS(MAX_WORDS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_tvalid),
        .o_tready (o_s_tready),
        .i_action (i_s_tuser[0]),
        .i_data   (i_s_tdata[31:0]),
        .i_count  (i_s_tdata[34:32]),
        .i_last   (i_s_tlast),
        .o_we     (f_we),
        .o_waddr  (f_waddr),
        .o_wdata  (f_wdata),
        .o_push   (push),
        .o_job    (f_job),
        .i_done   (done)
    );

    xxtea_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    // The front end only writes while no job is open, so the engine never
    // competes with it for the write port.
    xxtea_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (f_we || b_we),
        .i_waddr (b_we ? b_waddr : f_waddr),
        .i_wdata (b_we ? b_wdata : f_wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    xxtea_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (pop),
        .i_key       (key_fixed),
        .i_add_len   (r_add_len),
        .o_we        (b_we),
        .o_waddr     (b_waddr),
        .o_wdata     (b_wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_tvalid    (o_m_tvalid),
        .i_tready    (i_m_tready),
        .o_word      (o_m_tdata[31:0]),
        .o_vb        (out_vb),
        .o_last      (o_m_tlast),
        .o_status    (o_m_tuser),
        .o_done      (done)
    );

    assign o_m_tdata[34:32] = out_vb;
    assign o_m_tdata[39:35] = 5'd0;

endmodule
